/* design/wrs_pkg.sv */
package wrs_pkg;

  localparam int ID_W       = 8;
  localparam int IN_SHARE_W = 17;

  typedef enum logic [1:0] {
    OP_ADD_EQ = 2'd0,
    OP_ADD_W  = 2'd1,
    OP_REMOVE = 2'd2,
    OP_DRAW   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2,
    ST_DUP     = 2'd3
  } status_t;

  typedef struct packed {
    logic    capture;
    logic    rd_scan;
    logic    scan_upd;
    logic    eq_start;
    logic    eq_take;
    logic    rw_init;
    logic    rd_rw;
    logic    new_entry;
    logic    calc;
    logic    ar_take;
    logic    wr;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    out_load;
    logic    draw_res;
    status_t status;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic count_zero;
    logic count_one;
    logic count_full;
    logic found;
    logic at_pos;
    logic scan_last;
    logic rw_last;
    logic need_arith;
    logic ar_done;
    logic out_free;
  } sts_t;

endpackage

/* design/wrs_arith.sv */
module wrs_arith #(
  parameter int SHARE_W = 17
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic                   is_div,
  input  logic [2*SHARE_W-1:0]   opa,
  input  logic [SHARE_W-1:0]     opb,
  output logic                   done,
  output logic [2*SHARE_W-1:0]   result
);

  localparam int SW  = SHARE_W;
  localparam int DW  = 2 * SHARE_W;
  localparam int STW = $clog2(DW + 1);

  logic           busy_r, done_r, div_r;
  logic [STW-1:0] step_r;
  logic [SW:0]    rem_r;
  logic [DW-1:0]  quo_r;
  logic [SW-1:0]  dvs_r;

  logic [SW:0]    rem_sh, diff, msum, rem_n;
  logic [DW-1:0]  quo_n;
  logic           ge, last;

  always_comb begin
    // restoring divide: one quotient bit a cycle
    rem_sh = {rem_r[SW-1:0], quo_r[DW-1]};
    diff   = rem_sh - {1'b0, dvs_r};
    ge     = rem_sh >= {1'b0, dvs_r};
    // shift-add multiply: hi in rem_r, multiplier in low half of quo_r
    msum   = rem_r + (quo_r[0] ? {1'b0, dvs_r} : '0);
    if (div_r) begin
      rem_n = ge ? diff : rem_sh;
      quo_n = {quo_r[DW-2:0], ge};
    end else begin
      rem_n = {1'b0, msum[SW:1]};
      quo_n = {quo_r[DW-1:SW], msum[0], quo_r[SW-1:1]};
    end
    last = div_r ? (step_r == STW'(DW - 1)) : (step_r == STW'(SW - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && last) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      div_r  <= is_div;
      step_r <= '0;
      rem_r  <= '0;
      dvs_r  <= opb;
      quo_r  <= is_div ? opa : {{SW{1'b0}}, opa[SW-1:0]};
    end else if (busy_r) begin
      step_r <= step_r + STW'(1);
      rem_r  <= rem_n;
      quo_r  <= quo_n;
    end
  end

  assign done   = done_r;
  assign result = div_r ? quo_r : {rem_r[SW-1:0], quo_r[SW-1:0]};

endmodule

/* design/wrs_ctrl.sv */
module wrs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  wrs_pkg::sts_t sts,
  output wrs_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_EVAL, S_EQ_DIV,
    S_RW_RD, S_RW_CALC, S_RW_ARITH, S_RW_WR, S_DONE
  } state_t;

  state_t           state_r, state_nxt;
  wrs_pkg::status_t status_r, status_nxt;
  logic             draw_r, draw_nxt;

  always_comb begin
    cmd        = '0;
    state_nxt  = state_r;
    status_nxt = status_r;
    draw_nxt   = draw_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = sts.count_zero ? S_EVAL : S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        cmd.rd_scan = 1'b1;
        state_nxt   = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        cmd.scan_upd = 1'b1;
        state_nxt    = sts.scan_last ? S_EVAL : S_SCAN_RD;
      end
      S_EVAL: begin
        draw_nxt   = 1'b0;
        status_nxt = wrs_pkg::ST_OK;
        state_nxt  = S_DONE;
        case (sts.op)
          wrs_pkg::OP_DRAW: begin
            if (sts.count_zero) status_nxt = wrs_pkg::ST_MISSING;
            else draw_nxt = 1'b1;
          end
          wrs_pkg::OP_REMOVE: begin
            if (!sts.found) begin
              status_nxt = wrs_pkg::ST_MISSING;
            end else if (sts.count_one) begin
              cmd.cnt_dec = 1'b1;
            end else begin
              cmd.rw_init = 1'b1;
              state_nxt   = S_RW_RD;
            end
          end
          default: begin
            if (sts.found) begin
              status_nxt = wrs_pkg::ST_DUP;
            end else if (sts.count_full) begin
              status_nxt = wrs_pkg::ST_FULL;
            end else if (sts.op == wrs_pkg::OP_ADD_EQ) begin
              cmd.eq_start = 1'b1;
              state_nxt    = S_EQ_DIV;
            end else begin
              cmd.rw_init = 1'b1;
              state_nxt   = S_RW_RD;
            end
          end
        endcase
      end
      S_EQ_DIV: begin
        if (sts.ar_done) begin
          cmd.eq_take = 1'b1;
          cmd.rw_init = 1'b1;
          state_nxt   = S_RW_RD;
        end
      end
      S_RW_RD: begin
        if (sts.op != wrs_pkg::OP_REMOVE && sts.at_pos) begin
          cmd.new_entry = 1'b1;
          state_nxt     = S_RW_WR;
        end else begin
          cmd.rd_rw = 1'b1;
          state_nxt = S_RW_CALC;
        end
      end
      S_RW_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = sts.need_arith ? S_RW_ARITH : S_RW_WR;
      end
      S_RW_ARITH: begin
        if (sts.ar_done) begin
          cmd.ar_take = 1'b1;
          state_nxt   = S_RW_WR;
        end
      end
      S_RW_WR: begin
        cmd.wr = 1'b1;
        if (sts.rw_last) begin
          if (sts.op == wrs_pkg::OP_REMOVE) cmd.cnt_dec = 1'b1;
          else cmd.cnt_inc = 1'b1;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_RW_RD;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    cmd.status   = status_r;
    cmd.draw_res = draw_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      status_r <= wrs_pkg::ST_OK;
      draw_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
      draw_r   <= draw_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

endmodule

/* design/wrs_dpath.sv */
module wrs_dpath #(
  parameter int MAX_RECEIVERS   = 16,
  parameter int SHARE_FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  wrs_pkg::cmd_t                   cmd,
  output wrs_pkg::sts_t                   sts,
  input  logic [1:0]                      in_op,
  input  logic [wrs_pkg::ID_W-1:0]        in_id,
  input  logic [wrs_pkg::IN_SHARE_W-1:0]  in_share,
  input  logic [wrs_pkg::IN_SHARE_W-1:0]  in_rv,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [wrs_pkg::ID_W-1:0]        out_id,
  output logic [1:0]                      out_status
);

  localparam int F    = SHARE_FRAC_BITS;
  localparam int SW   = F + 1;
  localparam int DW   = 2 * SW;
  localparam int IW   = $clog2(MAX_RECEIVERS);
  localparam int CW   = $clog2(MAX_RECEIVERS + 1);
  localparam int SUMW = SW + CW;
  localparam int PW   = (SW > wrs_pkg::IN_SHARE_W) ? SW : wrs_pkg::IN_SHARE_W;
  localparam int CMPW = (SUMW > wrs_pkg::IN_SHARE_W) ? SUMW : wrs_pkg::IN_SHARE_W;
  localparam int IDW  = wrs_pkg::ID_W;
  localparam logic [SW-1:0] ONE = {1'b1, {F{1'b0}}};

  logic [IDW-1:0] id_mem    [MAX_RECEIVERS];
  logic [SW-1:0]  share_mem [MAX_RECEIVERS];

  wrs_pkg::op_t                   op_r;
  logic [IDW-1:0]                 id_r, rd_id_r, wr_id_r, drawn_r, last_r, out_id_r;
  logic [SW-1:0]                  p_r, r_r, eq_r, rd_share_r, wr_share_r;
  logic [wrs_pkg::IN_SHARE_W-1:0] rv_r;
  logic [IW-1:0]                  ptr_r, slot_r;
  logic [CW-1:0]                  count_r, pos_r;
  logic [SUMW-1:0]                sum_r;
  logic                           found_r, hit_r, out_valid_r;
  logic [1:0]                     out_status_r;

  logic [IW-1:0]   src, rd_addr;
  logic [SUMW-1:0] sum_add;
  logic [SW-1:0]   p_cap, quo_sat;
  logic            ar_go, ar_div, ar_done, need_arith;
  logic [DW-1:0]   ar_a, ar_res;
  logic [SW-1:0]   ar_b;

  always_comb begin
    if (op_r == wrs_pkg::OP_REMOVE) src = (ptr_r < slot_r) ? ptr_r : ptr_r + IW'(1);
    else src = (CW'(ptr_r) > pos_r) ? ptr_r - IW'(1) : ptr_r;
    rd_addr = cmd.rd_rw ? src : ptr_r;
    sum_add = sum_r + SUMW'(rd_share_r);
    p_cap   = (PW'(in_share) > PW'(ONE)) ? ONE : SW'(in_share);
    need_arith = (op_r == wrs_pkg::OP_ADD_W) ||
                 (op_r == wrs_pkg::OP_REMOVE && r_r != ONE);
    ar_go  = cmd.eq_start || (cmd.calc && need_arith);
    ar_div = cmd.eq_start || (op_r == wrs_pkg::OP_REMOVE);
    if (cmd.eq_start) begin
      ar_a = DW'(ONE);
      ar_b = SW'(count_r) + SW'(1);
    end else if (op_r == wrs_pkg::OP_REMOVE) begin
      ar_a = DW'(rd_share_r) << F;
      ar_b = ONE - r_r;
    end else begin
      ar_a = DW'(rd_share_r);
      ar_b = ONE - p_r;
    end
    quo_sat = (ar_res > DW'(ONE)) ? ONE : ar_res[SW-1:0];
  end

  wrs_arith #(.SHARE_W(SW)) u_arith (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (ar_go),
    .is_div (ar_div),
    .opa    (ar_a),
    .opb    (ar_b),
    .done   (ar_done),
    .result (ar_res)
  );

  always_ff @(posedge clk) begin
    if (cmd.rd_scan || cmd.rd_rw) begin
      rd_id_r    <= id_mem[rd_addr];
      rd_share_r <= share_mem[rd_addr];
    end
    if (cmd.wr) begin
      id_mem[ptr_r]    <= wr_id_r;
      share_mem[ptr_r] <= wr_share_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= wrs_pkg::op_t'(in_op);
      id_r    <= in_id;
      p_r     <= p_cap;
      rv_r    <= in_rv;
      ptr_r   <= '0;
      sum_r   <= '0;
      pos_r   <= '0;
      found_r <= 1'b0;
      hit_r   <= 1'b0;
    end
    if (cmd.scan_upd) begin
      sum_r  <= sum_add;
      last_r <= rd_id_r;
      ptr_r  <= ptr_r + IW'(1);
      if (rd_id_r == id_r) begin
        found_r <= 1'b1;
        slot_r  <= ptr_r;
        r_r     <= rd_share_r;
      end
      if (rd_id_r < id_r) pos_r <= pos_r + CW'(1);
      // first running sum that reaches the threshold wins
      if (!hit_r && CMPW'(sum_add) >= CMPW'(rv_r)) begin
        hit_r   <= 1'b1;
        drawn_r <= rd_id_r;
      end
    end
    if (cmd.eq_take) eq_r <= ar_res[SW-1:0];
    if (cmd.rw_init) ptr_r <= (op_r == wrs_pkg::OP_REMOVE) ? '0 : IW'(count_r);
    if (cmd.new_entry) begin
      wr_id_r    <= id_r;
      wr_share_r <= (op_r == wrs_pkg::OP_ADD_EQ) ? eq_r : p_r;
    end
    if (cmd.calc) begin
      wr_id_r    <= rd_id_r;
      wr_share_r <= (op_r == wrs_pkg::OP_ADD_EQ) ? eq_r : rd_share_r;
    end
    if (cmd.ar_take) begin
      wr_share_r <= (op_r == wrs_pkg::OP_ADD_W) ? ar_res[F +: SW] : quo_sat;
    end
    if (cmd.wr) ptr_r <= (op_r == wrs_pkg::OP_REMOVE) ? ptr_r + IW'(1) : ptr_r - IW'(1);
    if (cmd.out_load) begin
      out_id_r     <= cmd.draw_res ? (hit_r ? drawn_r : last_r) : '0;
      out_status_r <= cmd.status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.cnt_inc) count_r <= count_r + CW'(1);
      else if (cmd.cnt_dec) count_r <= count_r - CW'(1);
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    sts.op         = op_r;
    sts.count_zero = (count_r == '0);
    sts.count_one  = (count_r == CW'(1));
    sts.count_full = (count_r == CW'(MAX_RECEIVERS));
    sts.found      = found_r;
    sts.at_pos     = (CW'(ptr_r) == pos_r);
    sts.scan_last  = (CW'(ptr_r) == count_r - CW'(1));
    sts.rw_last    = (op_r == wrs_pkg::OP_REMOVE) ? (CW'(ptr_r) == count_r - CW'(2))
                                                  : (ptr_r == '0);
    sts.need_arith = need_arith;
    sts.ar_done    = ar_done;
    sts.out_free   = !out_valid_r || out_ready;
  end

  assign out_valid  = out_valid_r;
  assign out_id     = out_id_r;
  assign out_status = out_status_r;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_RECEIVERS)) else $error("entry count out of range");
  a_wr_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr |-> CW'(ptr_r) <= count_r) else $error("write beyond table end");
  a_inc_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_inc |-> !sts.count_full) else $error("insert into full table");
  a_dec_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_dec |-> !sts.count_zero) else $error("remove from empty table");
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free) else $error("result overwritten");
`endif

endmodule

/* design/weighted_random_receiver_select.sv */
// Each item first scans the stored entries (a read state, then a check state per entry); an add or
// remove then rewrites the entries in turn (read, calc, write), using the shared multiply/divide
// unit where a share must be computed. One item is handled at a time; a new one is taken in idle.
// Reset (rst_n low, synchronous) empties the table and clears the output beat.
module weighted_random_receiver_select #(
  parameter int MAX_RECEIVERS   = 16,
  parameter int SHARE_FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // receiver_id[7:0], share[24:8], random_value[41:25]
  input  logic [1:0]  in_tuser,   // op[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // drawn_id[7:0]
  output logic [1:0]  out_tuser   // status[1:0]
);

  wrs_pkg::cmd_t cmd;
  wrs_pkg::sts_t sts;

  wrs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  wrs_dpath #(
    .MAX_RECEIVERS   (MAX_RECEIVERS),
    .SHARE_FRAC_BITS (SHARE_FRAC_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_op      (in_tuser),
    .in_id      (in_tdata[7:0]),
    .in_share   (in_tdata[24:8]),
    .in_rv      (in_tdata[41:25]),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_id     (out_tdata),
    .out_status (out_tuser)
  );

endmodule
